@@ rtl/core/ilm_pkg.sv @@
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared types and constants for the interrupt latency monitor.
// ----------------------------------------------------------------------------
package ilm_pkg;

  localparam int HWIRQ_SLOTS   = 256;
  localparam int SOFTIRQ_SLOTS = 16;
  localparam int TIMER_SLOT    = HWIRQ_SLOTS + SOFTIRQ_SLOTS;
  localparam int HRTIMER_SLOT  = HWIRQ_SLOTS + SOFTIRQ_SLOTS + 1;
  localparam int SLOT_DEPTH    = HWIRQ_SLOTS + SOFTIRQ_SLOTS + 2;
  localparam int SLOT_W        = $clog2(SLOT_DEPTH);

  localparam int TIME_W  = 64;
  localparam int COUNT_W = 32;

  localparam logic [TIME_W-1:0] ALARM_RESET = 64'd500000;

  // input item layout
  localparam int IN_TDATA_W = 72;
  localparam int IN_TUSER_W = 3;
  // result item layout
  localparam int OUT_TDATA_W = 232;

  typedef enum logic [1:0] {
    KIND_HWIRQ   = 2'd0,
    KIND_SOFTIRQ = 2'd1,
    KIND_TIMER   = 2'd2,
    KIND_HRTIMER = 2'd3
  } ilm_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPD
  } ilm_state_t;

  // per-slot statistics entry
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  max_lat;
    logic [TIME_W-1:0]  min_lat;
  } ilm_stats_t;

endpackage

@@ rtl/core/interrupt_latency_monitor.sv @@
// ----------------------------------------------------------------------------
// interrupt_latency_monitor
// Per-source handler latency with min / max tracking, alarm flag and count.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  in_     | in  | tvalid / tready   | tdata: source_index, timestamp
//          |     |                   | tuser: kind, is_exit
//  out_    | out | tvalid / tready   | tdata: latency, over_threshold,
//          |     |                   |        min_latency, max_latency, count
//  cfg_    | in  | we (no wait)      | wdata: alarm_threshold
//
//  Entry items and ignored items (softirq index out of range) are done
//  on acceptance. An exit item takes three steps: memory read, subtract,
//  then update and write back; the memory read and the subtract are
//  registered. The next item is taken while the result waits.
//  After reset a clearing pass zeroes both memories, one slot per cycle,
//  all SLOT_DEPTH (274) slots; no item is taken meanwhile, cfg writes are.
//  A stalled result holds the update step until the output register frees.
//
module interrupt_latency_monitor
  import ilm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [7:0] source_index, [71:8] timestamp
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: [1:0] kind, [2] is_exit
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // out_tdata: [63:0] latency, [64] over_threshold, [128:65] min_latency,
  //            [192:129] max_latency, [224:193] event_count, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [TIME_W-1:0]      cfg_wdata
);

  ilm_state_t state_r, state_nxt;

  logic [SLOT_W-1:0]  clr_r;
  logic [TIME_W-1:0]  thr_r;

  // captured item
  logic [SLOT_W-1:0]  slot_r;
  logic [TIME_W-1:0]  ts_r;
  logic               irq_r;     // counted kind
  logic [TIME_W-1:0]  lat_r;

  // memories and their registered read data
  logic [TIME_W-1:0]  start_mem [SLOT_DEPTH];
  ilm_stats_t         stat_mem  [SLOT_DEPTH];
  logic [TIME_W-1:0]  start_rd_r;
  ilm_stats_t         stat_rd_r;

  // output register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // input decode
  ilm_kind_t          in_kind;
  logic [7:0]         in_idx;
  logic               in_exit;
  logic [TIME_W-1:0]  in_ts;
  logic               in_hit;
  logic [SLOT_W-1:0]  in_slot;
  logic               in_acc;

  // memory control
  logic               start_we;
  logic [SLOT_W-1:0]  start_waddr;
  logic [TIME_W-1:0]  start_wdata;
  logic               stat_we;
  logic [SLOT_W-1:0]  stat_waddr;
  ilm_stats_t         stat_wdata;
  logic               rd_en;
  logic               upd_go;

  // update math
  ilm_stats_t         upd_stats;
  logic               upd_over;

  assign in_kind = ilm_kind_t'(in_tuser[1:0]);
  assign in_exit = in_tuser[2];
  assign in_idx  = in_tdata[7:0];
  assign in_ts   = in_tdata[71:8];
  assign in_acc  = in_tvalid && in_tready;

  // slot map: hw irqs, then softirqs, then timer, then hrtimer
  always_comb begin
    unique case (in_kind)
      KIND_HWIRQ: begin
        in_hit  = 32'(in_idx) < 32'(HWIRQ_SLOTS);
        in_slot = SLOT_W'(in_idx);
      end
      KIND_SOFTIRQ: begin
        in_hit  = 32'(in_idx) < 32'(SOFTIRQ_SLOTS);
        in_slot = SLOT_W'(32'(HWIRQ_SLOTS) + 32'(in_idx));
      end
      KIND_TIMER: begin
        in_hit  = 1'b1;
        in_slot = SLOT_W'(TIMER_SLOT);
      end
      KIND_HRTIMER: begin
        in_hit  = 1'b1;
        in_slot = SLOT_W'(HRTIMER_SLOT);
      end
    endcase
  end

  // min: replaced when unset or beaten (a zero latency makes it unset again)
  always_comb begin
    upd_stats.min_lat = (lat_r < stat_rd_r.min_lat || stat_rd_r.min_lat == '0) ?
                        lat_r : stat_rd_r.min_lat;
    upd_stats.max_lat = (lat_r > stat_rd_r.max_lat) ? lat_r : stat_rd_r.max_lat;
    upd_stats.count   = irq_r ? stat_rd_r.count + COUNT_W'(1) : stat_rd_r.count;
    upd_over          = lat_r > thr_r;
  end

  assign upd_go = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == SLOT_W'(SLOT_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc && in_hit && in_exit) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_UPD;
      ST_UPD:   if (upd_go) state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready   = 1'b0;
    start_we    = 1'b0;
    start_waddr = in_slot;
    start_wdata = in_ts;
    stat_we     = 1'b0;
    stat_waddr  = slot_r;
    stat_wdata  = upd_stats;
    rd_en       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        start_we    = 1'b1;
        start_waddr = clr_r;
        start_wdata = '0;
        stat_we     = 1'b1;
        stat_waddr  = clr_r;
        stat_wdata  = '0;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        start_we  = in_acc && in_hit && !in_exit;
        rd_en     = in_acc && in_hit && in_exit;
      end
      ST_READ: ;
      ST_UPD: begin
        stat_we = upd_go;
      end
    endcase
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (start_we) start_mem[start_waddr] <= start_wdata;
    if (rd_en)    start_rd_r <= start_mem[in_slot];
  end

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[stat_waddr] <= stat_wdata;
    if (rd_en)   stat_rd_r <= stat_mem[in_slot];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      thr_r        <= ALARM_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + SLOT_W'(1);
      if (cfg_we) thr_r <= cfg_wdata;
      if (state_r == ST_UPD && upd_go) out_tvalid_r <= 1'b1;
      else if (out_tready)             out_tvalid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      slot_r <= in_slot;
      ts_r   <= in_ts;
      irq_r  <= (in_kind == KIND_HWIRQ) || (in_kind == KIND_SOFTIRQ);
    end
    if (state_r == ST_READ) lat_r <= ts_r - start_rd_r;
    if (state_r == ST_UPD && upd_go) begin
      out_tdata_r <= {7'd0,
                      irq_r ? upd_stats.count : COUNT_W'(0),
                      upd_stats.max_lat,
                      upd_stats.min_lat,
                      upd_over,
                      lat_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // an accepted exit item goes to the read step
  a_exit_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> state_r == ST_READ)
    else $error("exit item did not start a read");

  a_read_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_UPD)
    else $error("read step not followed by update");

  a_lat_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:0] <= out_tdata[192:129])
    else $error("latency above reported maximum");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[128:65] <= out_tdata[192:129])
    else $error("minimum above maximum");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_tready && !rd_en)
    else $error("item taken during clearing pass");

endmodule
